// ----- design/hrtm_pkg.sv -----
// ============================================================================
// hrtm_pkg
// Shared constants, types and functions of the Hamming ratio-test matcher.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hrtm_pkg;

   localparam int DESC_WORD_BITS = 64;
   localparam int MAX_WORDS      = 4;
   localparam int DIST_BITS      = 9;
   localparam int CNT_BITS       = 7;
   localparam int LEVEL_BITS     = 4;
   localparam int OCT_BITS       = 3;
   localparam int X_BITS         = 17;
   localparam int GATE_BITS      = 16;
   localparam int CFG_BITS       = 9;
   localparam int CSR_ADDR_BITS  = 8;

   localparam int INDEX_BITS_DEFAULT = 12;
   localparam int DESC_BITS_DEFAULT  = 256;

   // Request kinds.
   localparam logic REQ_LANDMARK  = 1'b0;
   localparam logic REQ_CANDIDATE = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DIST_THRESHOLD = 8'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LOWE_RATIO     = 8'd1;

   localparam logic [CFG_BITS-1:0] DIST_THRESHOLD_RESET = 9'd100;
   localparam logic [CFG_BITS-1:0] LOWE_RATIO_RESET     = 9'd154;

   // Octave code that marks an empty tracker slot.
   localparam logic [LEVEL_BITS-1:0] LEVEL_NONE = 4'hF;

   // Best and second-best tracker contents.
   typedef struct packed {
      logic                  found;
      logic [DIST_BITS-1:0]  top_dist;
      logic [DIST_BITS-1:0]  second_dist;
      logic [LEVEL_BITS-1:0] best_level;
      logic [LEVEL_BITS-1:0] second_level;
   } trk_snap_type;

   // Control of one tracker update.
   typedef struct packed {
      logic fire;   // a request leaves the distance stage
      logic load;   // it is a landmark load
      logic hit;    // it is a candidate that passed the gates
      logic last;   // it closes the landmark
   } trk_ctrl_type;

   // Population count of one descriptor word, counted per byte and then summed.
   function automatic logic [CNT_BITS-1:0] popcount64(input logic [DESC_WORD_BITS-1:0] w);
      logic [3:0]          byte_cnt;
      logic [CNT_BITS-1:0] total;
      total = '0;
      for (int b = 0; b < 8; b++) begin
         byte_cnt = '0;
         for (int i = 0; i < 8; i++) begin
            byte_cnt = byte_cnt + {3'b000, w[b*8+i]};
         end
         total = total + {3'b000, byte_cnt};
      end
      return total;
   endfunction

endpackage

`default_nettype wire

// ----- design/hrtm_tracker.sv -----
// ============================================================================
// hrtm_tracker
// Best and second-best distance tracker with octave and index bookkeeping.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hrtm_tracker
   import hrtm_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
   parameter int MAX_DIST   = DESC_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire trk_ctrl_type          ctrl,
   input  wire logic [DIST_BITS-1:0]  cand_dist,
   input  wire logic [LEVEL_BITS-1:0] cand_level,
   input  wire logic [INDEX_BITS-1:0] cand_index,
   output trk_snap_type               post_snap,
   output logic [INDEX_BITS-1:0]      post_index
);

   localparam logic [DIST_BITS-1:0] MAXD_V = DIST_BITS'(MAX_DIST);
   localparam trk_snap_type TRK_CLEAR = '{
      found:        1'b0,
      top_dist:     MAXD_V,
      second_dist:  MAXD_V,
      best_level:   LEVEL_NONE,
      second_level: LEVEL_NONE
   };

   trk_snap_type            trk_ff, trk_in, base;
   logic [INDEX_BITS-1:0]   idx_ff, idx_in, base_idx;

   always_comb begin
      base     = ctrl.load ? TRK_CLEAR : trk_ff;
      base_idx = ctrl.load ? '0 : idx_ff;
      post_snap  = base;
      post_index = base_idx;
      if (ctrl.hit) begin
         post_snap.found = 1'b1;
         // A tie with the best keeps the earlier best and may take second place.
         if (cand_dist < base.top_dist) begin
            post_snap.second_dist  = base.top_dist;
            post_snap.second_level = base.best_level;
            post_snap.top_dist     = cand_dist;
            post_snap.best_level   = cand_level;
            post_index             = cand_index;
         end else if (cand_dist < base.second_dist) begin
            post_snap.second_dist  = cand_dist;
            post_snap.second_level = cand_level;
         end
      end
      trk_in = ctrl.last ? TRK_CLEAR : post_snap;
      idx_in = ctrl.last ? '0 : post_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_ff <= TRK_CLEAR;
         idx_ff <= '0;
      end else if (ctrl.fire) begin
         trk_ff <= trk_in;
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/hamming_ratio_test_matcher_core.sv -----
// ============================================================================
// hamming_ratio_test_matcher_core
// Binary descriptor matcher with stereo gating and Lowe's ratio test.
// ============================================================================
// A landmark request (req_type 0) loads a 256-bit descriptor, the predicted
// right-camera x and a gate width, and restarts the search. Candidate
// requests (req_type 1) follow; a candidate is skipped when it is taken or
// when its positive stereo x lies more than the gate away from the landmark.
// Survivors are ranked by Hamming distance. A request with last set produces
// exactly one response: match_valid is high when the best distance is within
// dist_threshold and, if best and second-best share an octave, when
// best * 256 <= lowe_ratio * second. The block takes one request per clock
// unless a stall holds the input, as described below.
// The pipeline is an input register, a popcount/gate stage, a distance sum
// and tracker stage, and a ratio-test stage that feeds the output register.
// The tracker update is the only loop; its registers feed back through logic alone.
// Requests keep flowing while a response waits to be taken. Only when both
// the output register and the ratio stage hold a response does a further
// closing request stop in the tracker stage, and the input stalls once the
// request behind it fills the input register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hamming_ratio_test_matcher_core
   import hrtm_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
   parameter int DESC_BITS  = DESC_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // Configuration write channel.
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0]    csr_index,
   input  wire logic [CFG_BITS-1:0]         csr_wdata,
   // Request channel.
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [DESC_WORD_BITS-1:0]   req_desc_word0,
   input  wire logic [DESC_WORD_BITS-1:0]   req_desc_word1,
   input  wire logic [DESC_WORD_BITS-1:0]   req_desc_word2,
   input  wire logic [DESC_WORD_BITS-1:0]   req_desc_word3,
   input  wire logic [INDEX_BITS-1:0]       req_cand_index,
   input  wire logic [OCT_BITS-1:0]         req_cand_octave,
   input  wire logic                        req_cand_taken,
   input  wire logic signed [X_BITS-1:0]    req_x_right,
   input  wire logic [GATE_BITS-1:0]        req_gate,
   input  wire logic                        req_last,
   // Response channel.
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_match_valid,
   output logic [INDEX_BITS-1:0]            rsp_best_index,
   output logic [DIST_BITS-1:0]             rsp_best_distance
);

   // Only whole 64-bit words take part, at most the four that the ports carry.
   localparam int NWORDS   = ((DESC_BITS / DESC_WORD_BITS) > MAX_WORDS) ?
                             MAX_WORDS : (DESC_BITS / DESC_WORD_BITS);
   localparam int MAX_DIST = NWORDS * DESC_WORD_BITS;
   localparam int DIFF_BITS = X_BITS + 1;
   localparam int PROD_BITS = 2 * CFG_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken.
   // ---------------------------------------------------------------------
   logic [CFG_BITS-1:0] dist_thr_ff;
   logic [CFG_BITS-1:0] lowe_ratio_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_thr_ff   <= DIST_THRESHOLD_RESET;
         lowe_ratio_ff <= LOWE_RATIO_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIST_THRESHOLD: dist_thr_ff   <= csr_wdata;
            CSR_LOWE_RATIO:     lowe_ratio_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control. Each stage moves when the one after it is free
   // or moving. Only requests with last set occupy the ratio stage, so the
   // front of the pipe keeps running while a response waits.
   // ---------------------------------------------------------------------
   logic p1_valid_ff, p2_valid_ff, p3_valid_ff, rsp_valid_ff;
   logic p2_last_ff;
   logic out_free, p3_free, p3_adv, p2_adv, p2_free, p1_adv, p1_free;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      p3_adv   = p3_valid_ff && out_free;
      p3_free  = !p3_valid_ff || out_free;
      p2_adv   = p2_valid_ff && (!p2_last_ff || p3_free);
      p2_free  = !p2_valid_ff || p2_adv;
      p1_adv   = p1_valid_ff && p2_free;
      p1_free  = !p1_valid_ff || p2_free;
   end

   assign req_ready = p1_free;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (p1_free) begin
            p1_valid_ff <= req_valid;
         end
         if (p2_free) begin
            p2_valid_ff <= p1_valid_ff;
         end
         if (p3_free) begin
            p3_valid_ff <= p2_adv && p2_last_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= p3_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Input register.
   // ---------------------------------------------------------------------
   logic [DESC_WORD_BITS-1:0] req_desc [MAX_WORDS];
   logic [DESC_WORD_BITS-1:0] p1_desc_ff [NWORDS];
   logic                      p1_type_ff;
   logic [INDEX_BITS-1:0]     p1_index_ff;
   logic [OCT_BITS-1:0]       p1_octave_ff;
   logic                      p1_taken_ff;
   logic signed [X_BITS-1:0]  p1_x_ff;
   logic [GATE_BITS-1:0]      p1_gate_ff;
   logic                      p1_last_ff;

   assign req_desc[0] = req_desc_word0;
   assign req_desc[1] = req_desc_word1;
   assign req_desc[2] = req_desc_word2;
   assign req_desc[3] = req_desc_word3;

   always_ff @(posedge clock) begin
      if (req_valid && p1_free) begin
         for (int w = 0; w < NWORDS; w++) begin
            p1_desc_ff[w] <= req_desc[w];
         end
         p1_type_ff   <= req_type;
         p1_index_ff  <= req_cand_index;
         p1_octave_ff <= req_cand_octave;
         p1_taken_ff  <= req_cand_taken;
         p1_x_ff      <= req_x_right;
         p1_gate_ff   <= req_gate;
         p1_last_ff   <= req_last;
      end
   end

   // ---------------------------------------------------------------------
   // Landmark registers, written when a landmark request leaves the input
   // register, so the candidate right behind it already sees the new data.
   // ---------------------------------------------------------------------
   logic [DESC_WORD_BITS-1:0] lm_desc_ff [NWORDS];
   logic signed [X_BITS-1:0]  lm_x_ff;
   logic [GATE_BITS-1:0]      lm_gate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NWORDS; w++) begin
            lm_desc_ff[w] <= '0;
         end
         lm_x_ff    <= '0;
         lm_gate_ff <= '0;
      end else if (p1_adv && (p1_type_ff == REQ_LANDMARK)) begin
         for (int w = 0; w < NWORDS; w++) begin
            lm_desc_ff[w] <= p1_desc_ff[w];
         end
         lm_x_ff    <= p1_x_ff;
         lm_gate_ff <= p1_gate_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: per-word popcount of the XOR and the stereo gate.
   // ---------------------------------------------------------------------
   logic [CNT_BITS-1:0]   cnt_in [NWORDS];
   logic signed [DIFF_BITS-1:0] x_diff;
   logic [DIFF_BITS-1:0]  x_absdiff;
   logic                  x_present;
   logic                  skip_in;

   always_comb begin
      for (int w = 0; w < NWORDS; w++) begin
         cnt_in[w] = popcount64(lm_desc_ff[w] ^ p1_desc_ff[w]);
      end
      x_diff    = DIFF_BITS'(lm_x_ff) - DIFF_BITS'(p1_x_ff);
      x_absdiff = x_diff[DIFF_BITS-1] ? DIFF_BITS'(-x_diff) : DIFF_BITS'(x_diff);
      // A nonpositive stereo x means the candidate has no right-camera match.
      x_present = !p1_x_ff[X_BITS-1] && (p1_x_ff != '0);
      skip_in   = p1_taken_ff ||
                  (x_present && (x_absdiff > {{(DIFF_BITS-GATE_BITS){1'b0}}, lm_gate_ff}));
   end

   logic [CNT_BITS-1:0]   p2_cnt_ff [NWORDS];
   logic                  p2_type_ff;
   logic                  p2_skip_ff;
   logic [INDEX_BITS-1:0] p2_index_ff;
   logic [OCT_BITS-1:0]   p2_octave_ff;

   always_ff @(posedge clock) begin
      if (p1_adv) begin
         for (int w = 0; w < NWORDS; w++) begin
            p2_cnt_ff[w] <= cnt_in[w];
         end
         p2_type_ff   <= p1_type_ff;
         p2_skip_ff   <= skip_in;
         p2_index_ff  <= p1_index_ff;
         p2_octave_ff <= p1_octave_ff;
         p2_last_ff   <= p1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: distance sum and the best/second tracker.
   // ---------------------------------------------------------------------
   logic [DIST_BITS-1:0]  dist_sum;
   trk_ctrl_type          trk_ctrl;
   trk_snap_type          post_snap;
   logic [INDEX_BITS-1:0] post_index;

   always_comb begin
      dist_sum = '0;
      for (int w = 0; w < NWORDS; w++) begin
         dist_sum = dist_sum + DIST_BITS'(p2_cnt_ff[w]);
      end
      trk_ctrl.fire = p2_adv;
      trk_ctrl.load = (p2_type_ff == REQ_LANDMARK);
      trk_ctrl.hit  = (p2_type_ff == REQ_CANDIDATE) && !p2_skip_ff;
      trk_ctrl.last = p2_last_ff;
   end

   hrtm_tracker #(
      .INDEX_BITS (INDEX_BITS),
      .MAX_DIST   (MAX_DIST)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (trk_ctrl),
      .cand_dist  (dist_sum),
      .cand_level ({1'b0, p2_octave_ff}),
      .cand_index (p2_index_ff),
      .post_snap  (post_snap),
      .post_index (post_index)
   );

   // The tracker contents after the closing request, held for the ratio test.
   trk_snap_type          p3_snap_ff;
   logic [INDEX_BITS-1:0] p3_index_ff;

   always_ff @(posedge clock) begin
      if (p2_adv && p2_last_ff) begin
         p3_snap_ff  <= post_snap;
         p3_index_ff <= post_index;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: threshold and ratio test. best * 256 is compared exactly with
   // lowe_ratio * second; the test applies only when both octaves agree.
   // ---------------------------------------------------------------------
   logic [PROD_BITS-1:0] ratio_prod;
   logic [PROD_BITS-1:0] best_scaled;
   logic                 thr_ok;
   logic                 ratio_reject;
   logic                 match_in;

   always_comb begin
      ratio_prod   = PROD_BITS'(lowe_ratio_ff) * PROD_BITS'(p3_snap_ff.second_dist);
      best_scaled  = {1'b0, p3_snap_ff.top_dist, 8'h00};
      thr_ok       = p3_snap_ff.found && (p3_snap_ff.top_dist <= dist_thr_ff);
      ratio_reject = (p3_snap_ff.best_level == p3_snap_ff.second_level) &&
                     (best_scaled > ratio_prod);
      match_in     = thr_ok && !ratio_reject;
   end

   logic                  rsp_match_ff;
   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic [DIST_BITS-1:0]  rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (p3_adv) begin
         rsp_match_ff <= match_in;
         rsp_index_ff <= p3_index_ff;
         rsp_dist_ff  <= p3_snap_ff.top_dist;
      end
   end

   assign rsp_match_valid   = rsp_match_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

`default_nettype wire

// ----- dv/tb_hamming_ratio_test_matcher_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_hamming_ratio_test_matcher_core
// Self-checking testbench for the Hamming ratio-test matcher core.
// ============================================================================
// A behavioral predictor tracks the landmark, the best and second-best
// candidates and the two registers. It is updated on every accepted request
// and queues one expected response per request with last set. A checker
// compares each accepted response with the oldest expected one, field by
// field. Directed tests cover stereo gating, ties, the ratio test and the
// register extremes. A backpressure test fills the core while the response
// side is held off. Random traffic then runs in phases with different
// register settings and idle patterns on both channels.
// ============================================================================

module tb_hamming_ratio_test_matcher_core
   import hrtm_pkg::*;
();

   localparam int DESC_W = MAX_WORDS * DESC_WORD_BITS;
   localparam int IDX_W  = INDEX_BITS_DEFAULT;

   // One request as seen on the request channel.
   typedef struct {
      logic                     kind;
      logic [DESC_W-1:0]        desc;
      logic [IDX_W-1:0]         index;
      logic [OCT_BITS-1:0]      octave;
      logic                     taken;
      logic signed [X_BITS-1:0] x;
      logic [GATE_BITS-1:0]     gate;
      logic                     last;
   } matcher_request_type;

   // One response as expected on the response channel.
   typedef struct {
      logic                 match;
      logic [IDX_W-1:0]     index;
      logic [DIST_BITS-1:0] distance;
   } match_result_type;

   // -------------------------------------------------------------------------
   // Clock, reset and the signals of the core.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_ADDR_BITS-1:0]   csr_index = '0;
   logic [CFG_BITS-1:0]        csr_wdata = '0;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = 1'b0;
   logic [DESC_WORD_BITS-1:0]  req_desc_word0 = '0;
   logic [DESC_WORD_BITS-1:0]  req_desc_word1 = '0;
   logic [DESC_WORD_BITS-1:0]  req_desc_word2 = '0;
   logic [DESC_WORD_BITS-1:0]  req_desc_word3 = '0;
   logic [IDX_W-1:0]           req_cand_index = '0;
   logic [OCT_BITS-1:0]        req_cand_octave = '0;
   logic                       req_cand_taken = 1'b0;
   logic signed [X_BITS-1:0]   req_x_right = '0;
   logic [GATE_BITS-1:0]       req_gate = '0;
   logic                       req_last = 1'b0;

   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_match_valid;
   logic [IDX_W-1:0]           rsp_best_index;
   logic [DIST_BITS-1:0]       rsp_best_distance;

   hamming_ratio_test_matcher_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_desc_word0    (req_desc_word0),
      .req_desc_word1    (req_desc_word1),
      .req_desc_word2    (req_desc_word2),
      .req_desc_word3    (req_desc_word3),
      .req_cand_index    (req_cand_index),
      .req_cand_octave   (req_cand_octave),
      .req_cand_taken    (req_cand_taken),
      .req_x_right       (req_x_right),
      .req_gate          (req_gate),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_valid   (rsp_match_valid),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance)
   );

   // -------------------------------------------------------------------------
   // Shared test state.
   // -------------------------------------------------------------------------
   int  error_count = 0;
   bit  req_idle_on = 1'b1;   // random gaps between requests
   bit  rsp_idle_on = 1'b1;   // random stalls on the response side
   int  rsp_hold_cycles = 0;  // length of a requested response hold-off
   int  rsp_hold_seq = 0;     // bumped to ask the response side for a hold-off

   match_result_type pending_matches[$];

   // Predictor state: the loaded landmark, the trackers and the registers.
   logic [DESC_W-1:0]        lm_desc;
   logic signed [X_BITS-1:0] lm_x;
   logic [GATE_BITS-1:0]     lm_gate;
   int                       trk_top_dist;
   int                       trk_second_dist;
   logic [LEVEL_BITS-1:0]    trk_best_level;
   logic [LEVEL_BITS-1:0]    trk_second_level;
   logic [IDX_W-1:0]         trk_best_index;
   bit                       trk_found;
   int                       cfg_dist_threshold;
   int                       cfg_lowe_ratio;

   // -------------------------------------------------------------------------
   // Predictor.
   // -------------------------------------------------------------------------
   function automatic void clear_trackers();
      trk_top_dist     = DESC_W;
      trk_second_dist  = DESC_W;
      trk_best_level   = LEVEL_NONE;
      trk_second_level = LEVEL_NONE;
      trk_best_index   = '0;
      trk_found        = 1'b0;
   endfunction

   // Applies one accepted request to the trackers. A request with last set
   // closes the landmark and queues the response the core must give for it.
   function automatic void predict_match(input matcher_request_type r);
      int               hdist;
      int               dx;
      bit               skip;
      match_result_type res;
      if (r.kind == REQ_LANDMARK) begin
         lm_desc = r.desc;
         lm_x    = r.x;
         lm_gate = r.gate;
         clear_trackers();
      end else begin
         skip = r.taken;
         // A nonpositive stereo x means the candidate has no right view, so
         // the gate does not apply to it.
         if (!skip && r.x > 0) begin
            dx = lm_x - r.x;
            if (dx < 0) begin
               dx = -dx;
            end
            if (dx > int'(lm_gate)) begin
               skip = 1'b1;
            end
         end
         if (!skip) begin
            hdist     = $countones(lm_desc ^ r.desc);
            trk_found = 1'b1;
            // A tie with the best only displaces the second-best.
            if (hdist < trk_top_dist) begin
               trk_second_dist  = trk_top_dist;
               trk_second_level = trk_best_level;
               trk_top_dist     = hdist;
               trk_best_level   = {1'b0, r.octave};
               trk_best_index   = r.index;
            end else if (hdist < trk_second_dist) begin
               trk_second_dist  = hdist;
               trk_second_level = {1'b0, r.octave};
            end
         end
      end
      if (r.last) begin
         res.match = trk_found && (trk_top_dist <= cfg_dist_threshold);
         // The ratio test only applies when both candidates sit on the same
         // pyramid level. Both sides are scaled to integers, so no rounding.
         if (res.match && trk_best_level == trk_second_level &&
             trk_top_dist * 256 > cfg_lowe_ratio * trk_second_dist) begin
            res.match = 1'b0;
         end
         res.index    = trk_best_index;
         res.distance = trk_top_dist[DIST_BITS-1:0];
         pending_matches.push_back(res);
         clear_trackers();
      end
   endfunction

   // -------------------------------------------------------------------------
   // Monitor and checker. Everything is sampled at the rising edge. The
   // response is checked before the request of the same edge is predicted,
   // so a response can never be matched against an expectation that its
   // own edge created.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      matcher_request_type seen;
      match_result_type    want;
      if (reset) begin
         cfg_dist_threshold = int'(DIST_THRESHOLD_RESET);
         cfg_lowe_ratio     = int'(LOWE_RATIO_RESET);
         lm_desc            = '0;
         lm_x               = '0;
         lm_gate            = '0;
         clear_trackers();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_matches.size() == 0) begin
               $error({"response with no expectation waiting: ",
                       "match_valid %0d index %0d distance %0d"},
                      rsp_match_valid, rsp_best_index, rsp_best_distance);
               error_count++;
            end else begin
               want = pending_matches.pop_front();
               if (rsp_match_valid !== want.match) begin
                  $error("match_valid: expected %0d, got %0d", want.match, rsp_match_valid);
                  error_count++;
               end
               if (rsp_best_index !== want.index) begin
                  $error("best_index: expected %0d, got %0d", want.index, rsp_best_index);
                  error_count++;
               end
               if (rsp_best_distance !== want.distance) begin
                  $error("best_distance: expected %0d, got %0d",
                         want.distance, rsp_best_distance);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIST_THRESHOLD: cfg_dist_threshold = int'(csr_wdata);
               CSR_LOWE_RATIO:     cfg_lowe_ratio = int'(csr_wdata);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            seen.kind   = req_type;
            seen.desc   = {req_desc_word3, req_desc_word2, req_desc_word1, req_desc_word0};
            seen.index  = req_cand_index;
            seen.octave = req_cand_octave;
            seen.taken  = req_cand_taken;
            seen.x      = req_x_right;
            seen.gate   = req_gate;
            seen.last   = req_last;
            predict_match(seen);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Idle pattern: mostly back-to-back, some short gaps, a few long ones.
   // -------------------------------------------------------------------------
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   // Response side. It stalls at random, and on request it holds ready low
   // for rsp_hold_cycles, a hold-off that it counts itself.
   initial begin : response_sink
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      forever begin
         @(negedge clock);
         if (hold_seen != rsp_hold_seq) begin
            hold_seen = rsp_hold_seq;
            hold_left = rsp_hold_cycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(rsp_idle_on);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request construction.
   // -------------------------------------------------------------------------
   function automatic logic [DESC_W-1:0] random_descriptor();
      logic [DESC_W-1:0] d;
      for (int i = 0; i < DESC_W / 32; i++) begin
         d[i*32 +: 32] = $urandom;
      end
      return d;
   endfunction

   // Flips exactly n distinct bits, which sets the Hamming distance exactly.
   function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] d, input int n);
      logic [DESC_W-1:0] mask;
      int                pos;
      int                flipped;
      mask    = '0;
      flipped = 0;
      while (flipped < n) begin
         pos = $urandom_range(0, DESC_W - 1);
         if (!mask[pos]) begin
            mask[pos] = 1'b1;
            flipped++;
         end
      end
      return d ^ mask;
   endfunction

   // Candidate fields of a landmark request are unused, so they get noise.
   function automatic matcher_request_type landmark_request(input logic [DESC_W-1:0] d,
                                                            input int x, input int g,
                                                            input bit last);
      matcher_request_type r;
      r.kind   = REQ_LANDMARK;
      r.desc   = d;
      r.x      = X_BITS'(x);
      r.gate   = GATE_BITS'(g);
      r.last   = last;
      r.index  = IDX_W'($urandom);
      r.octave = OCT_BITS'($urandom);
      r.taken  = 1'($urandom);
      return r;
   endfunction

   function automatic matcher_request_type candidate_request(input logic [DESC_W-1:0] d,
                                                             input int idx, input int oct,
                                                             input bit taken, input int x,
                                                             input bit last);
      matcher_request_type r;
      r.kind   = REQ_CANDIDATE;
      r.desc   = d;
      r.index  = IDX_W'(idx);
      r.octave = OCT_BITS'(oct);
      r.taken  = taken;
      r.x      = X_BITS'(x);
      r.last   = last;
      r.gate   = GATE_BITS'($urandom);
      return r;
   endfunction

   // A candidate for the landmark (lm, lx, g). Most descriptors are close to
   // the landmark so that the threshold and the ratio test both matter, and
   // half of the stereo values sit around the gate boundary.
   function automatic matcher_request_type random_candidate(input logic [DESC_W-1:0] lm,
                                                            input int lx, input int g,
                                                            input bit last);
      logic [DESC_W-1:0] d;
      int                r;
      int                x;
      int                oct;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         d = flip_bits(lm, $urandom_range(0, 60));
      end else if (r < 80) begin
         d = flip_bits(lm, $urandom_range(0, 5));
      end else begin
         d = random_descriptor();
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
         x = 0 - int'($urandom_range(0, 65536));
      end else if (r < 80) begin
         x = lx + int'($urandom_range(0, 2 * g + 8)) - g - 4;
         if (x > 65535) begin
            x = 65535;
         end
         if (x < -65536) begin
            x = -65536;
         end
      end else begin
         x = int'($urandom_range(0, 131071)) - 65536;
      end
      oct = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 1) : $urandom_range(0, 7);
      return candidate_request(d, $urandom_range(0, 4095), oct,
                               $urandom_range(0, 9) == 0, x, last);
   endfunction

   // -------------------------------------------------------------------------
   // Channel drivers. Inputs change on the falling edge only.
   // -------------------------------------------------------------------------

   // Offers one request and returns once it has been accepted. Valid stays
   // high into the next call when no gap is drawn, so a burst ends with
   // end_burst to withdraw it.
   task automatic send_request(input matcher_request_type r);
      int gap;
      gap = pick_gap(req_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type        <= r.kind;
      req_desc_word0  <= r.desc[63:0];
      req_desc_word1  <= r.desc[127:64];
      req_desc_word2  <= r.desc[191:128];
      req_desc_word3  <= r.desc[255:192];
      req_cand_index  <= r.index;
      req_cand_octave <= r.octave;
      req_cand_taken  <= r.taken;
      req_x_right     <= r.x;
      req_gate        <= r.gate;
      req_last        <= r.last;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Waits until every expected response has arrived, then lets the
   // pipeline drain any request that produces no response.
   task automatic wait_idle();
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // Right after reset: a candidate with no landmark loaded is matched
   // against the all-zero landmark, and a landmark load that closes at once
   // reports that no candidate survived.
   task automatic test_reset_state();
      send_request(candidate_request('0, 4095, 7, 1'b0, 0, 1'b1));
      send_request(landmark_request('1, 65535, 65535, 1'b1));
      end_burst();
   endtask

   // Taken candidates and the stereo gate, including a candidate exactly on
   // the gate edge, one without a right view and the extremes of x. After
   // the response the same landmark stays loaded for the next candidate.
   task automatic test_stereo_gating();
      logic [DESC_W-1:0] lm;
      lm = random_descriptor();
      send_request(landmark_request(lm, 1000, 32, 1'b0));
      send_request(candidate_request(lm, 1, 0, 1'b1, 1000, 1'b0));
      send_request(candidate_request(lm, 2, 0, 1'b0, 1033, 1'b0));
      send_request(candidate_request(flip_bits(lm, 5), 3, 1, 1'b0, 968, 1'b0));
      send_request(candidate_request(~lm, 4, 1, 1'b0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 10), 5, 2, 1'b0, -65536, 1'b0));
      send_request(candidate_request(lm, 6, 0, 1'b0, 65535, 1'b1));
      send_request(candidate_request(lm, 7, 0, 1'b0, 1000, 1'b1));
      end_burst();
   endtask

   // Ranking: a tie with the best goes to second place and the first best is
   // kept. The ratio test rejects close pairs on the same octave and passes
   // a clearly better best.
   task automatic test_ranking_ties();
      logic [DESC_W-1:0] lm;
      lm = random_descriptor();
      send_request(landmark_request(lm, 0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 20), 1, 2, 1'b0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 20), 2, 2, 1'b0, 0, 1'b1));
      send_request(candidate_request(flip_bits(lm, 10), 3, 3, 1'b0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 12), 4, 3, 1'b0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 40), 5, 4, 1'b0, 0, 1'b1));
      send_request(candidate_request(flip_bits(lm, 10), 6, 5, 1'b0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 30), 7, 5, 1'b0, 0, 1'b1));
      end_burst();
   endtask

   // Both registers at zero, at the top of their range and at the largest
   // value their 9 bits can hold.
   task automatic test_register_extremes();
      logic [DESC_W-1:0] lm;
      lm = random_descriptor();
      write_register(CSR_DIST_THRESHOLD, 9'd0);
      write_register(CSR_LOWE_RATIO, 9'd0);
      send_request(landmark_request(lm, 500, 0, 1'b0));
      send_request(candidate_request(lm, 1, 1, 1'b0, 500, 1'b0));
      send_request(candidate_request(flip_bits(lm, 1), 2, 1, 1'b0, 0, 1'b1));
      end_burst();
      write_register(CSR_DIST_THRESHOLD, 9'd256);
      write_register(CSR_LOWE_RATIO, 9'd256);
      send_request(candidate_request(~lm, 4095, 7, 1'b0, 0, 1'b1));
      end_burst();
      write_register(CSR_DIST_THRESHOLD, 9'd511);
      write_register(CSR_LOWE_RATIO, 9'd511);
      send_request(candidate_request(flip_bits(lm, 100), 3, 5, 1'b0, 0, 1'b0));
      send_request(candidate_request(flip_bits(lm, 101), 4, 5, 1'b0, 0, 1'b1));
      end_burst();
   endtask

   // The response side holds off for a long stretch while every candidate
   // closes the landmark, so responses pile up until the core stops taking
   // requests. The sender keeps offering without gaps the whole time.
   task automatic test_backpressure();
      logic [DESC_W-1:0] lm;
      lm = random_descriptor();
      req_idle_on = 1'b0;
      send_request(landmark_request(lm, 2000, 200, 1'b0));
      rsp_hold_cycles = 300;
      rsp_hold_seq++;
      for (int i = 0; i < 50; i++) begin
         send_request(random_candidate(lm, 2000, 200, 1'b1));
      end
      end_burst();
      req_idle_on = 1'b1;
   endtask

   // Register values: the two range ends, any 9-bit value, or a typical one.
   function automatic logic [CFG_BITS-1:0] pick_setting(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return 9'd0;
      end
      if (r < 30) begin
         return 9'd256;
      end
      if (r < 38) begin
         return CFG_BITS'($urandom_range(0, 511));
      end
      return CFG_BITS'($urandom_range(lo, hi));
   endfunction

   // Mostly well-formed landmarks followed by a few candidates with the last
   // one closing; the rest is closing landmark loads, stray candidates
   // against whatever landmark is still loaded, and fully random requests.
   task automatic run_random_phase(input int n_items);
      matcher_request_type r;
      logic [DESC_W-1:0]   lm;
      int                  lx;
      int                  g;
      int                  sent;
      int                  n_cand;
      int                  pick;
      lm   = random_descriptor();
      lx   = 0;
      g    = 0;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            lm   = random_descriptor();
            lx   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 65535)
                                              : int'($urandom_range(0, 65536)) - 65536;
            pick = $urandom_range(0, 9);
            g    = (pick < 5) ? $urandom_range(0, 200) :
                   (pick < 8) ? $urandom_range(0, 65535) :
                   (pick < 9) ? 0 : 65535;
            send_request(landmark_request(lm, lx, g, 1'b0));
            n_cand = $urandom_range(1, 10);
            for (int i = 1; i <= n_cand; i++) begin
               send_request(random_candidate(lm, lx, g, i == n_cand));
            end
            sent += n_cand + 1;
         end else if (pick < 87) begin
            send_request(landmark_request(random_descriptor(), $urandom_range(0, 131071),
                                          $urandom_range(0, 65535), 1'b1));
            sent++;
         end else if (pick < 94) begin
            send_request(random_candidate(lm, lx, g, 1'($urandom_range(0, 1))));
            sent++;
         end else begin
            r.kind   = 1'($urandom);
            r.desc   = random_descriptor();
            r.index  = IDX_W'($urandom);
            r.octave = OCT_BITS'($urandom);
            r.taken  = 1'($urandom);
            r.x      = X_BITS'($urandom);
            r.gate   = GATE_BITS'($urandom);
            r.last   = 1'($urandom);
            send_request(r);
            sent++;
         end
      end
      end_burst();
   endtask

   // Ten phases, each with fresh register settings and its own idle
   // pattern. The first phase runs with no idling on either side.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         write_register(CSR_DIST_THRESHOLD, pick_setting(40, 140));
         write_register(CSR_LOWE_RATIO, pick_setting(100, 230));
         req_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         run_random_phase(100);
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_stereo_gating();
      test_ranking_ties();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("PASS hamming_ratio_test_matcher_core");
      end else begin
         $display("FAIL hamming_ratio_test_matcher_core");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this.
   initial begin
      #10_000_000;
      $display("FAIL hamming_ratio_test_matcher_core");
      $finish;
   end

endmodule
